### rtl/core/asesu_pkg.sv
package asesu_pkg;

  // Column bound and the widths that follow from it
  localparam int MAX_COLUMNS = 4096;
  localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
  localparam int OUT_CNT_W   = 13;
  localparam int EXT_W       = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
  localparam int SAT_MAX     = (1 << OUT_CNT_W) - 1;

  localparam int CFG_W   = 8;
  localparam int SCORE_W = 23;
  localparam int OUT_SCORE_W = 22;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = -SCORE_W'(2097152);
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = SCORE_W'(1048575);

  // Operation kinds
  localparam logic [1:0] KIND_SUB = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_INS = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_MATCH    = 3'd0;
  localparam logic [2:0] REG_MISMATCH = 3'd1;
  localparam logic [2:0] REG_OPEN     = 3'd2;
  localparam logic [2:0] REG_EXTEND   = 3'd3;
  localparam logic [2:0] REG_GAP_CODE = 3'd4;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CFG_W-1:0] match_reward;
    logic [CFG_W-1:0] mismatch_penalty;
    logic [CFG_W-1:0] gap_open_cost;
    logic [CFG_W-1:0] gap_extend_cost;
    logic [CFG_W-1:0] gap_code;
  } cfg_t;

  typedef struct packed {
    logic                          done_res;
    logic                          overflow;
    logic [OUT_CNT_W-1:0]          columns;
    logic [OUT_CNT_W-1:0]          gap_columns;
    logic [OUT_CNT_W-1:0]          gap_runs;
    logic [OUT_CNT_W-1:0]          op_count;
    logic [OUT_CNT_W-1:0]          identities;
    logic signed [OUT_SCORE_W-1:0] total_score;
    logic [OUT_CNT_W-1:0]          op_length;
    logic [1:0]                    op_kind;
  } result_t;

  // Up to two results per item; the second is only ever valid with the first
  typedef struct packed {
    logic    va;
    logic    vb;
    result_t a;
    result_t b;
  } push_t;

  function automatic logic [OUT_CNT_W-1:0] sat13(input logic [CNT_W-1:0] v);
    logic [EXT_W-1:0] x;
    begin
      x = EXT_W'(v);
      if (x > EXT_W'(SAT_MAX)) sat13 = OUT_CNT_W'(SAT_MAX);
      else sat13 = x[OUT_CNT_W-1:0];
    end
  endfunction

endpackage

### rtl/core/asesu_core.sv
module asesu_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                query_char,
  input  logic [7:0]                subject_char,
  input  logic                      last_column,
  input  asesu_pkg::cfg_t           cfg,
  output asesu_pkg::push_t          push
);
  import asesu_pkg::*;

  logic [1:0]               run_kind;
  logic                     run_active;
  logic [CNT_W-1:0]         run_length;
  logic signed [SCORE_W-1:0] score_acc;
  logic [CNT_W-1:0]         ident_count, ops_count, opens_count, gapcol_count, col_count;
  logic                     overflow_flag;

  logic                     in_range, qg, sg, cont, closed, opens;
  logic [1:0]               cls;
  logic [1:0]               kind_upd;
  logic                     active_upd;
  logic [CNT_W-1:0]         len_upd, ident_upd, ops_upd, opens_upd, gapcol_upd, col_upd;
  logic signed [SCORE_W-1:0] delta, score_sum, score_upd;
  logic                     ovf_upd;
  result_t                  totals, res_closed, res_final;

  always_comb begin
    in_range = !overflow_flag && (col_count < CNT_W'(MAX_COLUMNS));
    qg = (query_char == cfg.gap_code);
    sg = (subject_char == cfg.gap_code);
    if (!qg && !sg) cls = KIND_SUB;
    else if (run_active && run_kind == KIND_INS && sg) cls = KIND_INS;
    else if (run_active && run_kind == KIND_DEL && qg) cls = KIND_DEL;
    else if (qg) cls = KIND_DEL;
    else cls = KIND_INS;

    cont   = run_active && (cls == run_kind);
    closed = in_range && run_active && !cont;
    opens  = in_range && !cont && (cls != KIND_SUB);

    // Open and extend costs are both subtracted, so one clamp covers them
    if (cls == KIND_SUB) begin
      if (query_char == subject_char) delta = SCORE_W'(cfg.match_reward);
      else delta = -SCORE_W'(cfg.mismatch_penalty);
    end else begin
      delta = -(SCORE_W'(cfg.gap_extend_cost) +
                (opens ? SCORE_W'(cfg.gap_open_cost) : SCORE_W'(0)));
    end
    score_sum = score_acc + delta;
    if (!in_range) score_upd = score_acc;
    else if (score_sum < SCORE_MIN) score_upd = SCORE_MIN;
    else if (score_sum > SCORE_MAX) score_upd = SCORE_MAX;
    else score_upd = score_sum;

    kind_upd   = in_range ? cls : run_kind;
    active_upd = run_active || in_range;
    if (!in_range) len_upd = run_length;
    else if (cont) len_upd = run_length + CNT_W'(1);
    else len_upd = CNT_W'(1);

    ident_upd  = ident_count + CNT_W'(in_range && cls == KIND_SUB &&
                                       query_char == subject_char);
    gapcol_upd = gapcol_count + CNT_W'(in_range && cls != KIND_SUB);
    col_upd    = col_count + CNT_W'(in_range);
    opens_upd  = opens_count + CNT_W'(opens);
    ops_upd    = ops_count + CNT_W'(closed) + CNT_W'(last_column && active_upd);
    ovf_upd    = overflow_flag || !in_range;

    totals.done_res    = 1'b0;
    totals.overflow    = ovf_upd;
    totals.columns     = sat13(col_upd);
    totals.gap_columns = sat13(gapcol_upd);
    totals.gap_runs    = sat13(opens_upd);
    totals.op_count    = sat13(ops_upd);
    totals.identities  = sat13(ident_upd);
    totals.total_score = score_upd[OUT_SCORE_W-1:0];
    totals.op_length   = '0;
    totals.op_kind     = KIND_SUB;

    res_closed           = totals;
    res_closed.op_kind   = run_kind;
    res_closed.op_length = sat13(run_length);

    res_final           = totals;
    res_final.done_res  = 1'b1;
    res_final.op_kind   = active_upd ? kind_upd : KIND_SUB;
    res_final.op_length = active_upd ? sat13(len_upd) : '0;

    // Closed run first, then the totals on the last column
    push.va = accept && (closed || last_column);
    push.vb = accept && closed && last_column;
    push.a  = closed ? res_closed : res_final;
    push.b  = res_final;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_column)) begin
      run_kind      <= KIND_SUB;
      run_active    <= 1'b0;
      run_length    <= '0;
      score_acc     <= '0;
      ident_count   <= '0;
      ops_count     <= '0;
      opens_count   <= '0;
      gapcol_count  <= '0;
      col_count     <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      run_kind      <= kind_upd;
      run_active    <= active_upd;
      run_length    <= len_upd;
      score_acc     <= score_upd;
      ident_count   <= ident_upd;
      ops_count     <= ops_upd;
      opens_count   <= opens_upd;
      gapcol_count  <= gapcol_upd;
      col_count     <= col_upd;
      overflow_flag <= ovf_upd;
    end
  end

endmodule

### rtl/core/asesu_outq.sv
module asesu_outq (
  input  logic               clk,
  input  logic               rst,
  input  asesu_pkg::push_t   push,
  input  logic               pop,
  output logic               has_room,
  output logic               not_empty,
  output asesu_pkg::result_t head
);
  import asesu_pkg::*;

  result_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;

  assign has_room  = (count <= QCNT_W'(QDEPTH - 2));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_comb begin
    count_next = count + QCNT_W'(push.va) + QCNT_W'(push.vb) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.va) mem[wr_ptr] <= push.a;
    if (push.vb) mem[wr_ptr + QPTR_W'(1)] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.va) + QPTR_W'(push.vb);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

### rtl/core/alignment_scorer_edit_script_unit.sv
// Affine-gap alignment scorer and edit-script encoder.
// Slave stream: one alignment column per item. s_tdata carries the query and
// subject characters, s_tlast marks the final column of an alignment.
// Master stream: one item per closed edit operation plus a final item,
// flagged by m_tlast, carrying the last run and the totals for score,
// identities, operations, gap runs, gap columns and length. m_tuser holds
// the operation kind, m_tdata the run length and the totals.
// APB port: five 8-bit registers at byte offsets 0..16 (match reward,
// mismatch penalty, gap open cost, gap extend cost, gap code); write them
// only while the stream is idle.
// Throughput: one column per cycle while s_tready is high, set by the update
// of the run and score registers. Results are registered in the output
// queue before they reach m_tvalid. A final column that also closes a run
// yields two items, drained one after the other.
// Results wait in a four-entry queue; s_tready is held low while fewer than
// two entries are free, so a stalled receiver back-pressures the input
// without loss.
// Reset (rst, synchronous): empty the queue, clear the run state and totals,
// and load the register defaults.
module alignment_scorer_edit_script_unit (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // query_char[7:0], subject_char[15:8]
  input  logic        s_tlast,   // last_column
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [103:0] m_tdata,  // op_length[12:0], total_score[34:13],
                                 // identities[47:35], op_count[60:48],
                                 // gap_runs[73:61], gap_columns[86:74],
                                 // columns[99:87], overflow[100], zero[103:101]
  output logic [1:0]  m_tuser,   // op_kind[1:0]
  output logic        m_tlast,   // done_res
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import asesu_pkg::*;

  cfg_t    cfg;
  push_t   push;
  result_t head;
  logic    accept, pop, has_room;
  logic    cfg_write;
  logic [2:0] reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Register file: accept writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_reward     <= 8'd2;
      cfg.mismatch_penalty <= 8'd3;
      cfg.gap_open_cost    <= 8'd5;
      cfg.gap_extend_cost  <= 8'd2;
      cfg.gap_code         <= 8'd45;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_MATCH:    cfg.match_reward     <= pwdata[CFG_W-1:0];
        REG_MISMATCH: cfg.mismatch_penalty <= pwdata[CFG_W-1:0];
        REG_OPEN:     cfg.gap_open_cost    <= pwdata[CFG_W-1:0];
        REG_EXTEND:   cfg.gap_extend_cost  <= pwdata[CFG_W-1:0];
        REG_GAP_CODE: cfg.gap_code         <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MATCH:    prdata = 32'(cfg.match_reward);
      REG_MISMATCH: prdata = 32'(cfg.mismatch_penalty);
      REG_OPEN:     prdata = 32'(cfg.gap_open_cost);
      REG_EXTEND:   prdata = 32'(cfg.gap_extend_cost);
      REG_GAP_CODE: prdata = 32'(cfg.gap_code);
      default:      prdata = '0;
    endcase
  end

  // Take a column only when the queue can absorb both possible results
  assign s_tready = has_room;
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  asesu_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .query_char   (s_tdata[7:0]),
    .subject_char (s_tdata[15:8]),
    .last_column  (s_tlast),
    .cfg          (cfg),
    .push         (push)
  );

  asesu_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .has_room  (has_room),
    .not_empty (m_tvalid),
    .head      (head)
  );

  assign m_tdata = {3'b000, head.overflow, head.columns, head.gap_columns, head.gap_runs,
                    head.op_count, head.identities, head.total_score, head.op_length};
  assign m_tuser = head.op_kind;
  assign m_tlast = head.done_res;

endmodule

### rtl/core/asesu_checker.sv
module asesu_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tlast
);
  import asesu_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  // Queue is empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A final column accepted while no result is pending yields a result
  a_final: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast && !m_tvalid |=> m_tvalid)
    else $error("final column produced no result");

  // Overflow only once the column bound is reached
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[100] |-> m_tdata[99:87] == sat13(CNT_W'(MAX_COLUMNS)))
    else $error("overflow before column bound");

  // Input back-pressure releases only when a result drains
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready && !(m_tvalid && m_tready) |=> !s_tready)
    else $error("ready rose without a drain");

endmodule

bind alignment_scorer_edit_script_unit asesu_checker u_asesu_checker (.*);
